FILE: rtl/lbsh_pkg.sv
// Package for the lookup2 byte stream hash unit: job and word types, hash constants
// and the single-row mix function used by the back part.
// No dependencies.
package lbsh_pkg;

	localparam logic [31:0] GOLDEN_WORD       = 32'h9E37_79B9;
	localparam logic [31:0] DEFAULT_INITIAL_C = 32'hE635_9A60;
	localparam int          BLOCK_BYTES       = 12;
	localparam int          MIX_ROWS          = 9;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} lbsh_words_t;

	// One unit of work for the back part: words to add, and what follows the mix.
	typedef struct packed {
		logic [31:0] wa;
		logic [31:0] wb;
		logic [31:0] wc;
		logic [31:0] len;
		logic        first;
		logic        is_last;
		logic        post_len;
	} lbsh_job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_LEN,
		ST_EMIT
	} lbsh_state_t;

	// One row of the mix: a single word takes two subtractions and an xor of a shifted word.
	function automatic lbsh_words_t mix_row(input lbsh_words_t w, input logic [3:0] row);
		lbsh_words_t r;
		r = w;
		unique case (row)
			4'd0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
			4'd1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
			4'd2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
			4'd3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
			4'd4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
			4'd5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
			4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
			4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
			4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
			default: r = w;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/lbsh_front.sv
// Front part of the lookup2 byte stream hash unit: collects bytes into 12-byte blocks
// and turns each full block or message tail into a job for the back part.
// Depends on lbsh_pkg.
module lbsh_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  job_push,
	output lbsh_pkg::lbsh_job_t   job
);

	localparam int NB = lbsh_pkg::BLOCK_BYTES;

	logic [3:0]  pos_q;
	logic        in_msg_q;
	logic        first_pend_q;
	logic [31:0] len_q;
	logic [7:0]  bytes_q [NB-1];

	logic [3:0]  eff_pos;
	logic        block_full;
	logic        first;
	logic [31:0] len_new;
	logic [7:0]  view [NB];

	always_comb begin
		eff_pos    = in_msg_q ? pos_q : 4'd0;
		block_full = (eff_pos == 4'(NB - 1));
		first      = in_msg_q ? first_pend_q : 1'b1;
		len_new    = in_msg_q ? len_q + 32'd1 : 32'd1;
		// The block as it stands once the current byte is in; bytes past it read as zero.
		for (int i = 0; i < NB; i++) begin
			if (4'(i) == eff_pos) begin
				view[i] = data_byte;
			end else if (i < NB - 1 && 4'(i) < eff_pos) begin
				view[i] = bytes_q[i < NB - 1 ? i : 0];
			end else begin
				view[i] = 8'd0;
			end
		end
	end

	always_comb begin
		job.wa      = {view[3], view[2], view[1], view[0]};
		job.wb      = {view[7], view[6], view[5], view[4]};
		job.len     = len_new;
		job.first   = first;
		job.is_last = last_byte;
		if (block_full) begin
			job.wc       = {view[11], view[10], view[9], view[8]};
			job.post_len = last_byte;
		end else begin
			// Tail bytes of c sit one byte up; the low byte position carries the length.
			job.wc       = len_new + {view[10], view[9], view[8], 8'd0};
			job.post_len = 1'b0;
		end
		job_push = accept && (block_full || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= 4'd0;
			in_msg_q     <= 1'b0;
			first_pend_q <= 1'b0;
			len_q        <= 32'd0;
		end else if (accept) begin
			pos_q        <= (block_full || last_byte) ? 4'd0 : eff_pos + 4'd1;
			in_msg_q     <= !last_byte;
			first_pend_q <= job_push ? 1'b0 : first;
			len_q        <= len_new;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !block_full) begin
			bytes_q[eff_pos] <= data_byte;
		end
	end

endmodule

FILE: rtl/lbsh_queue.sv
// Short job queue between the front and back parts of the lookup2 byte stream hash unit.
// Depends on lbsh_pkg for the job type.
module lbsh_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lbsh_pkg::lbsh_job_t push_data,
	output logic                full,
	input  logic                pop,
	output lbsh_pkg::lbsh_job_t pop_data,
	output logic                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lbsh_pkg::lbsh_job_t mem [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/lbsh_back.sv
// Back part of the lookup2 byte stream hash unit: holds the words a, b and c, adds each
// job in and mixes one row per cycle, and keeps the finished hash in an output register.
// Depends on lbsh_pkg.
module lbsh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         initial_c,
	input  logic                job_valid,
	input  lbsh_pkg::lbsh_job_t job,
	output logic                job_pop,
	input  logic                out_pop,
	output logic                out_valid,
	output logic [31:0]         out_hash
);

	lbsh_pkg::lbsh_state_t state_q, state_d;
	lbsh_pkg::lbsh_words_t words_q, mixed;
	logic [31:0] len_q;
	logic        last_q;
	logic        post_q;
	logic [3:0]  round_q;
	logic        round_last;
	logic        slot_free;
	logic        emit_fire;
	logic        out_valid_q;
	logic [31:0] out_hash_q;

	assign mixed      = lbsh_pkg::mix_row(words_q, round_q);
	assign round_last = (round_q == 4'(lbsh_pkg::MIX_ROWS - 1));
	assign slot_free  = !out_valid_q || out_pop;
	assign out_valid  = out_valid_q;
	assign out_hash   = out_hash_q;

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		emit_fire = 1'b0;
		unique case (state_q)
			lbsh_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = lbsh_pkg::ST_MIX;
				end
			end
			lbsh_pkg::ST_MIX: begin
				if (round_last) begin
					if (post_q) begin
						state_d = lbsh_pkg::ST_LEN;
					end else if (last_q) begin
						state_d = lbsh_pkg::ST_EMIT;
					end else begin
						state_d = lbsh_pkg::ST_IDLE;
					end
				end
			end
			lbsh_pkg::ST_LEN: begin
				state_d = lbsh_pkg::ST_MIX;
			end
			lbsh_pkg::ST_EMIT: begin
				if (slot_free) begin
					emit_fire = 1'b1;
					state_d   = lbsh_pkg::ST_IDLE;
				end
			end
			default: state_d = lbsh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbsh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lbsh_pkg::ST_IDLE: begin
				if (job_valid) begin
					// The first job of a message starts from fresh words.
					words_q.a <= (job.first ? lbsh_pkg::GOLDEN_WORD : words_q.a) + job.wa;
					words_q.b <= (job.first ? lbsh_pkg::GOLDEN_WORD : words_q.b) + job.wb;
					words_q.c <= (job.first ? initial_c : words_q.c) + job.wc;
					len_q     <= job.len;
					last_q    <= job.is_last;
					post_q    <= job.post_len;
					round_q   <= 4'd0;
				end
			end
			lbsh_pkg::ST_MIX: begin
				words_q <= mixed;
				round_q <= round_q + 4'd1;
			end
			lbsh_pkg::ST_LEN: begin
				// A message that ends on a block boundary gets its length after the block mix.
				words_q.c <= words_q.c + len_q;
				post_q    <= 1'b0;
				round_q   <= 4'd0;
			end
			lbsh_pkg::ST_EMIT: begin
				if (emit_fire) begin
					out_hash_q <= words_q.c;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/lookup2_byte_stream_hash_unit.sv
// Top level of the lookup2 byte stream hash unit: front part, job queue and back part.
// Depends on lbsh_pkg, lbsh_front, lbsh_queue and lbsh_back.
//
//   channel   ports                          transaction
//   input     push, full, data_byte,         push && !full
//             last_byte
//   result    empty, pop, hash_value         pop && !empty
//   config    cfg_we, cfg_wdata              cfg_we (initial value of word c)
//
// The front takes one byte per cycle while full is low. Each full 12-byte block
// or message tail becomes one job; the back adds it in and mixes 9 rows, adds the
// length and mixes 9 more rows for a message that ends exactly on a block boundary,
// then hands over the hash; it takes a new job only from idle. full rises when the job
// queue holds QUEUE_DEPTH jobs; a waiting hash stalls the back part, and the input once
// the queue fills. Reset clears all control state and loads initial_c with 0xE6359A60.
module lookup2_byte_stream_hash_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] hash_value,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	logic                initial_c_q;
	logic [31:0]         init_c_q;
	logic                accept;
	logic                job_push;
	lbsh_pkg::lbsh_job_t front_job;
	lbsh_pkg::lbsh_job_t back_job;
	logic                queue_empty;
	logic                job_pop;
	logic                out_valid;

	assign accept = push && !full;
	assign empty  = !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_c_q    <= lbsh_pkg::DEFAULT_INITIAL_C;
			initial_c_q <= 1'b0;
		end else if (cfg_we) begin
			init_c_q    <= cfg_wdata;
			initial_c_q <= 1'b1;
		end
	end

	lbsh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.job_push  (job_push),
		.job       (front_job)
	);

	lbsh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (front_job),
		.full      (full),
		.pop       (job_pop),
		.pop_data  (back_job),
		.empty     (queue_empty)
	);

	lbsh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.initial_c (initial_c_q ? init_c_q : lbsh_pkg::DEFAULT_INITIAL_C),
		.job_valid (!queue_empty),
		.job       (back_job),
		.job_pop   (job_pop),
		.out_pop   (pop),
		.out_valid (out_valid),
		.out_hash  (hash_value)
	);

endmodule
